// ===== hdl/point_in_shape_test_macros.svh =====
// Assertion helpers for the top-level file, which checks its own logic.
`ifndef POINT_IN_SHAPE_TEST_MACROS_SVH
`define POINT_IN_SHAPE_TEST_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PIST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PIST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pist_pkg.sv =====
// ----------------------------------------------------------------------------
// pist_pkg
// Types and codes shared by the point-in-shape test block.
// ----------------------------------------------------------------------------
package pist_pkg;

    localparam logic [1:0] SHAPE_CIRCLE = 2'd0;
    localparam logic [1:0] SHAPE_RECT   = 2'd1;
    localparam logic [1:0] SHAPE_POLY   = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    localparam logic [2:0] REG_SHAPE_KIND   = 3'd0;
    localparam logic [2:0] REG_TRANSFORM    = 3'd1;
    localparam logic [2:0] REG_UPPER_BOUND  = 3'd2;
    localparam logic [2:0] REG_LOWER_BOUND  = 3'd3;
    localparam logic [2:0] REG_VERTEX_COUNT = 3'd4;

    localparam logic [63:0] TRANSFORM_RESET = 64'h4000_0000_0000_4000;

    typedef struct packed {
        logic               func;
        logic [5:0]         vertex_slot;
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
    } t_cmd;

    typedef struct packed {
        logic inside_res;
        logic on_edge;
        logic too_few_vertices;
    } t_res;

    // mapped point for a test, raw vertex for a load
    typedef struct packed {
        logic               func;
        logic [5:0]         vertex_slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_job;

    typedef struct packed {
        logic [1:0]  shape_kind;
        logic [63:0] transform_matrix;
        logic [63:0] upper_bound;
        logic [63:0] lower_bound;
        logic [6:0]  vertex_count;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== hdl/pist_front.sv =====
// ----------------------------------------------------------------------------
// pist_front
// Accepts commands and maps test points through the 2x2 Q2.14 transform.
// ----------------------------------------------------------------------------
module pist_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pist_pkg::t_cmd    i_cmd,
    input  logic [63:0]       i_matrix,
    input  pist_pkg::t_qstat  i_qstat,
    output logic              o_busy,
    output logic              o_push,
    output pist_pkg::t_job    o_job
);

    logic                r_v1;
    logic                r_v2;
    pist_pkg::t_cmd      r_c1;
    pist_pkg::t_cmd      r_c2;
    logic signed [47:0]  r_pxa;
    logic signed [47:0]  r_pxb;
    logic signed [47:0]  r_pya;
    logic signed [47:0]  r_pyb;
    logic signed [48:0]  sum_x;
    logic signed [48:0]  sum_y;
    logic signed [34:0]  q_x;
    logic signed [34:0]  q_y;
    logic                accept;

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
            r = v[31:0];
        end else if (v[34]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // one item in flight; the queue had room when it was taken
    assign o_busy = r_v1 | r_v2 | i_qstat.full;
    assign accept = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c1 <= i_cmd;
        end
        if (r_v1) begin
            r_c2  <= r_c1;
            r_pxa <= r_c1.coord_a * $signed(i_matrix[63:48]);
            r_pxb <= r_c1.coord_b * $signed(i_matrix[47:32]);
            r_pya <= r_c1.coord_a * $signed(i_matrix[31:16]);
            r_pyb <= r_c1.coord_b * $signed(i_matrix[15:0]);
        end
    end

    // arithmetic shift gives the floor of the Q2.14 scale
    always_comb begin
        sum_x = {r_pxa[47], r_pxa} + {r_pxb[47], r_pxb};
        sum_y = {r_pya[47], r_pya} + {r_pyb[47], r_pyb};
        q_x   = 35'(sum_x >>> 14);
        q_y   = 35'(sum_y >>> 14);
        o_job.func        = r_c2.func;
        o_job.vertex_slot = r_c2.vertex_slot;
        if (r_c2.func == pist_pkg::FUNC_LOAD) begin
            o_job.x = r_c2.coord_a;
            o_job.y = r_c2.coord_b;
        end else begin
            o_job.x = sat32(q_x);
            o_job.y = sat32(q_y);
        end
    end

    assign o_push = r_v2;

endmodule

// ===== hdl/pist_queue.sv =====
// ----------------------------------------------------------------------------
// pist_queue
// Four-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module pist_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pist_pkg::t_job    i_job,
    input  logic              i_pop,
    output pist_pkg::t_job    o_job,
    output pist_pkg::t_qstat  o_qstat
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    pist_pkg::t_job   r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [PW:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_job         = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == (PW+1)'(DEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

// ===== hdl/pist_back.sv =====
// ----------------------------------------------------------------------------
// pist_back
// Runs queued jobs: vertex loads, circle and rectangle tests, and the
// polygon edge walk over the vertex memory.
// ----------------------------------------------------------------------------
module pist_back #(
    parameter int MAX_VERTICES   = 64,
    parameter int EDGE_TOLERANCE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pist_pkg::t_cfg    i_cfg,
    input  pist_pkg::t_qstat  i_qstat,
    input  pist_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_done,
    output pist_pkg::t_res    o_res
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 2);
    localparam logic signed [66:0] TOL_C = 67'(EDGE_TOLERANCE) << 16;
    localparam logic signed [32:0] TOL_D = 33'(EDGE_TOLERANCE);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_SQUARE   = 3'd2;
    localparam logic [2:0] ST_CIRCLE   = 3'd3;
    localparam logic [2:0] ST_WALK     = 3'd4;

    logic [2:0]          r_state;
    pist_pkg::t_job      r_job;
    logic                r_done;
    pist_pkg::t_res      r_res;
    logic                r_few;

    logic [63:0]         r_mem [MAX_VERTICES];
    logic [63:0]         r_rdata;
    logic                wr_en;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;

    logic [CW-1:0]       n_cnt;
    logic [CW-1:0]       r_rd_cnt;
    logic                r_rv;
    logic                r_rfirst;
    logic [63:0]         r_prev;

    logic                r_dv;
    logic signed [32:0]  r_dx1;
    logic signed [32:0]  r_dy1;
    logic signed [32:0]  r_dx2;
    logic signed [32:0]  r_dy2;

    logic                r_mv;
    logic signed [65:0]  r_p1;
    logic signed [65:0]  r_p2;
    logic                r_mbox;
    logic                r_md1p;
    logic                r_md2p;

    logic                r_sv;
    logic signed [66:0]  r_c;
    logic                r_sbox;
    logic                r_sd1p;
    logic                r_sd2p;

    logic                r_hit;
    logic signed [CW:0]  r_wd;

    logic [63:0]         r_sqx;
    logic [63:0]         r_sqy;
    logic [63:0]         r_sqr;

    logic [31:0]         ux;
    logic [31:0]         uy;
    logic [31:0]         ur;
    logic                rect_in;
    logic                box_out;
    logic                walk_idle;
    logic                c_pos;
    logic                c_neg;
    logic                x_in;
    logic                y_in;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic signed [32:0] sx33(input logic [31:0] v);
        return {v[31], v};
    endfunction

    assign n_cnt = (32'(i_cfg.vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                             : CW'(i_cfg.vertex_count);

    assign o_pop = (r_state == ST_IDLE) && !i_qstat.empty;
    assign wr_en = o_pop && (i_job.func == pist_pkg::FUNC_LOAD)
                   && (32'(i_job.vertex_slot) < MAX_VERTICES);

    // read vertices 0..n-1 and then vertex 0 again to close the shape
    assign rd_en   = (r_state == ST_WALK) && (n_cnt != '0) && (r_rd_cnt <= n_cnt);
    assign rd_addr = (r_rd_cnt == n_cnt) ? '0 : r_rd_cnt[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[AW'(i_job.vertex_slot)] <= {i_job.x, i_job.y};
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        ux      = abs32(r_job.x);
        uy      = abs32(r_job.y);
        ur      = abs32(i_cfg.upper_bound[63:32]);
        rect_in = ($signed({1'b0, ux}) <= sx33(i_cfg.upper_bound[63:32]))
                  && ($signed({1'b0, uy}) <= sx33(i_cfg.upper_bound[31:0]));
        box_out = (r_job.x > $signed(i_cfg.upper_bound[63:32]))
                  || (r_job.y > $signed(i_cfg.upper_bound[31:0]))
                  || (r_job.x < $signed(i_cfg.lower_bound[63:32]))
                  || (r_job.y < $signed(i_cfg.lower_bound[31:0]));
        walk_idle = !rd_en && !r_rv && !r_dv && !r_mv && !r_sv;
        c_pos = r_c > TOL_C;
        c_neg = r_c < -TOL_C;
        // point within the closed box of the segment
        x_in = !((r_dx1 > 0) && (r_dx2 > 0)) && !((r_dx1 < 0) && (r_dx2 < 0));
        y_in = !((r_dy1 > 0) && (r_dy2 > 0)) && !((r_dy1 < 0) && (r_dy2 < 0));
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_done   <= 1'b0;
            r_rd_cnt <= '0;
            r_rv     <= 1'b0;
            r_dv     <= 1'b0;
            r_mv     <= 1'b0;
            r_sv     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_rv   <= rd_en;
            r_dv   <= r_rv && !r_rfirst;
            r_mv   <= r_dv;
            r_sv   <= r_mv;
            if (rd_en) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop && (i_job.func == pist_pkg::FUNC_TEST)) begin
                        r_state <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    case (i_cfg.shape_kind)
                        pist_pkg::SHAPE_CIRCLE: begin
                            r_state <= ST_SQUARE;
                        end
                        pist_pkg::SHAPE_POLY: begin
                            if (box_out) begin
                                r_done  <= 1'b1;
                                r_state <= ST_IDLE;
                            end else begin
                                r_rd_cnt <= '0;
                                r_state  <= ST_WALK;
                            end
                        end
                        default: begin
                            r_done  <= 1'b1;
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_SQUARE: begin
                    r_state <= ST_CIRCLE;
                end
                ST_CIRCLE: begin
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                ST_WALK: begin
                    if (walk_idle) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (rd_en) begin
            r_rfirst <= (r_rd_cnt == '0);
        end
        if (r_rv) begin
            r_prev <= r_rdata;
            r_dx1  <= sx33(r_prev[63:32]) - sx33(r_job.x);
            r_dy1  <= sx33(r_prev[31:0]) - sx33(r_job.y);
            r_dx2  <= sx33(r_rdata[63:32]) - sx33(r_job.x);
            r_dy2  <= sx33(r_rdata[31:0]) - sx33(r_job.y);
        end
        // both edge crosses reduce to dx1*dy2 - dy1*dx2
        r_p1   <= r_dx1 * r_dy2;
        r_p2   <= r_dy1 * r_dx2;
        r_mbox <= x_in && y_in;
        r_md1p <= r_dy1 > TOL_D;
        r_md2p <= r_dy2 > TOL_D;
        r_c    <= {r_p1[65], r_p1} - {r_p2[65], r_p2};
        r_sbox <= r_mbox;
        r_sd1p <= r_md1p;
        r_sd2p <= r_md2p;

        r_sqx <= ux * ux;
        r_sqy <= uy * uy;
        r_sqr <= ur * ur;

        if (r_state == ST_DISPATCH) begin
            r_hit <= 1'b0;
            r_wd  <= '0;
            r_few <= (n_cnt < CW'(3));
        end else if (r_sv) begin
            if (!c_pos && !c_neg && r_sbox) begin
                r_hit <= 1'b1;
            end
            if (c_pos && !r_sd1p && r_sd2p) begin
                r_wd <= r_wd + 1'b1;
            end else if (c_neg && !r_sd2p && r_sd1p) begin
                r_wd <= r_wd - 1'b1;
            end
        end

        case (r_state)
            ST_DISPATCH: begin
                case (i_cfg.shape_kind)
                    pist_pkg::SHAPE_RECT: begin
                        r_res <= '{inside_res: rect_in, on_edge: 1'b0,
                                   too_few_vertices: 1'b0};
                    end
                    pist_pkg::SHAPE_POLY: begin
                        r_res <= '{inside_res: 1'b0, on_edge: 1'b0,
                                   too_few_vertices: (n_cnt < CW'(3))};
                    end
                    default: begin
                        r_res <= '0;
                    end
                endcase
            end
            ST_CIRCLE: begin
                r_res <= '{inside_res: (({1'b0, r_sqx} + {1'b0, r_sqy}) <= {1'b0, r_sqr}),
                           on_edge: 1'b0, too_few_vertices: 1'b0};
            end
            ST_WALK: begin
                r_res <= '{inside_res: r_hit || (r_wd != '0), on_edge: r_hit,
                           too_few_vertices: r_few};
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hdl/point_in_shape_test.sv =====
// ----------------------------------------------------------------------------
// point_in_shape_test
// Tests a transformed point against a circle, rectangle or vertex polygon.
// ----------------------------------------------------------------------------
//  channel   signals                           direction
//  command   start, busy, i_cmd                in
//  result    o_done, o_res                     out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data   in
//
//  A command is taken when start is high and busy is low; the front then
//  holds busy while it maps the point (r_v1, r_v2), or while the queue is full.
//  Vertex loads write the vertex memory; a rectangle is decided in DISPATCH,
//  a circle passes SQUARE and CIRCLE, and a polygon runs the edge walk unless
//  the box rejects the point, reading one vertex per cycle from the vertex
//  memory. A result is on o_res when o_done is high for one cycle; the receiver
//  cannot stall. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`include "point_in_shape_test_macros.svh"

module point_in_shape_test #(
    parameter int MAX_VERTICES   = 64,
    parameter int EDGE_TOLERANCE = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  pist_pkg::t_cmd  i_cmd,
    output logic            o_done,
    output pist_pkg::t_res  o_res,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [63:0]     i_cfg_data
);

    pist_pkg::t_cfg    r_cfg;
    pist_pkg::t_qstat  qstat;
    pist_pkg::t_job    push_job;
    pist_pkg::t_job    pop_job;
    logic              push;
    logic              pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shape_kind       <= pist_pkg::SHAPE_CIRCLE;
            r_cfg.transform_matrix <= pist_pkg::TRANSFORM_RESET;
            r_cfg.upper_bound      <= '0;
            r_cfg.lower_bound      <= '0;
            r_cfg.vertex_count     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pist_pkg::REG_SHAPE_KIND:   r_cfg.shape_kind       <= i_cfg_data[1:0];
                pist_pkg::REG_TRANSFORM:    r_cfg.transform_matrix <= i_cfg_data;
                pist_pkg::REG_UPPER_BOUND:  r_cfg.upper_bound      <= i_cfg_data;
                pist_pkg::REG_LOWER_BOUND:  r_cfg.lower_bound      <= i_cfg_data;
                pist_pkg::REG_VERTEX_COUNT: r_cfg.vertex_count     <= i_cfg_data[6:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    pist_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_matrix (r_cfg.transform_matrix),
        .i_qstat  (qstat),
        .o_busy   (busy),
        .o_push   (push),
        .o_job    (push_job)
    );

    pist_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_qstat (qstat)
    );

    pist_back #(
        .MAX_VERTICES   (MAX_VERTICES),
        .EDGE_TOLERANCE (EDGE_TOLERANCE)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_qstat (qstat),
        .i_job   (pop_job),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    `PIST_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
    `PIST_ASSERT_SAME(a_no_overflow, push, !qstat.full, "push into full queue")
    `PIST_ASSERT_SAME(a_edge_inside, o_done && o_res.on_edge, o_res.inside_res, "edge hit not inside")
    `PIST_ASSERT_SAME(a_poly_flags, o_done && (o_res.on_edge || o_res.too_few_vertices), r_cfg.shape_kind == pist_pkg::SHAPE_POLY, "polygon flag on other shape")

endmodule

// ===== test/point_in_shape_test_test.sv =====
// ----------------------------------------------------------------------------
// point_in_shape_test_test
// Self-checking bench for the point-in-shape block. Loads vertex tables,
// sweeps circle, rectangle and polygon settings and random points, and
// compares every result strobe with a local prediction of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_shape_test_test;

    localparam int NVERT    = 64;
    localparam int TOL      = 64;
    localparam int WATCHDOG = 20000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    pist_pkg::t_cmd  i_cmd = '0;
    logic            o_done;
    pist_pkg::t_res  o_res;
    logic            i_cfg_we = 1'b0;
    logic [2:0]      i_cfg_idx = '0;
    logic [63:0]     i_cfg_data = '0;

    point_in_shape_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_done(o_done), .o_res(o_res), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [1:0]         kind_q;
    logic [63:0]        xform_q, upper_q, lower_q;
    logic [6:0]         nvert_q;
    logic signed [31:0] vx [NVERT];
    logic signed [31:0] vy [NVERT];

    pist_pkg::t_res  pending_res[$];
    int    mismatches = 0;
    int    n_results = 0;
    int    n_inside = 0;
    int    n_edge = 0;
    int    idle_cycles = 0;
    int    burst_left = 0;

    function automatic longint map_axis(longint a, longint b, logic [15:0] ca,
                                        logic [15:0] cb);
        longint p;
        longint q;
        p = a * longint'($signed(ca)) + b * longint'($signed(cb));
        q = p >>> 14;   // arithmetic shift floors
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    function automatic int tol_sign(logic signed [127:0] c, longint t);
        if (c > 128'(t)) return 1;
        if (c < -128'(t)) return -1;
        return 0;
    endfunction

    function automatic pist_pkg::t_res shape_result(pist_pkg::t_cmd c);
        pist_pkg::t_res r;
        longint x, y, r0, hx, hy, x1, y1, x2, y2, lo, hi, tol2;
        logic signed [127:0] cr;
        int n, j, k, d1, d2, wd;
        logic [127:0] ux, uy, ur;
        r = '0;
        x = map_axis(c.coord_a, c.coord_b, xform_q[63:48], xform_q[47:32]);
        y = map_axis(c.coord_a, c.coord_b, xform_q[31:16], xform_q[15:0]);
        case (kind_q)
            pist_pkg::SHAPE_CIRCLE: begin
                r0 = $signed(upper_q[63:32]);
                ux = x < 0 ? -x : x;
                uy = y < 0 ? -y : y;
                ur = r0 < 0 ? -r0 : r0;
                r.inside_res = (ux * ux + uy * uy) <= ur * ur;
            end
            pist_pkg::SHAPE_RECT: begin
                hx = $signed(upper_q[63:32]);
                hy = $signed(upper_q[31:0]);
                r.inside_res = ((x < 0 ? -x : x) <= hx) && ((y < 0 ? -y : y) <= hy);
            end
            pist_pkg::SHAPE_POLY: begin
                n = nvert_q > NVERT ? NVERT : nvert_q;
                tol2 = longint'(TOL) * 65536;
                r.too_few_vertices = n < 3;
                wd = 0;
                if (!(x > $signed(upper_q[63:32]) || y > $signed(upper_q[31:0]) ||
                      x < $signed(lower_q[63:32]) || y < $signed(lower_q[31:0]))) begin
                    for (int i = 0; i < n; i++) begin
                        j = (i + 1 == n) ? 0 : i + 1;
                        x1 = vx[i]; y1 = vy[i]; x2 = vx[j]; y2 = vy[j];
                        cr = 128'(y - y1) * 128'(x2 - x) - 128'(x - x1) * 128'(y2 - y);
                        lo = x1 < x2 ? x1 : x2;
                        hi = x1 < x2 ? x2 : x1;
                        if (tol_sign(cr, tol2) == 0 && x >= lo && x <= hi &&
                            y >= (y1 < y2 ? y1 : y2) && y <= (y1 < y2 ? y2 : y1)) begin
                            r.inside_res = 1'b1;
                            r.on_edge = 1'b1;
                            return r;
                        end
                        cr = 128'(x2 - x1) * 128'(y - y1) - 128'(y2 - y1) * 128'(x - x1);
                        k = tol_sign(cr, tol2);
                        d1 = (y1 - y) > TOL ? 1 : ((y1 - y) < -TOL ? -1 : 0);
                        d2 = (y2 - y) > TOL ? 1 : ((y2 - y) < -TOL ? -1 : 0);
                        if (k > 0 && d1 <= 0 && d2 > 0) wd++;
                        else if (k < 0 && d2 <= 0 && d1 > 0) wd--;
                    end
                    r.inside_res = wd != 0;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            n_results++;
            if (o_res.inside_res) n_inside++;
            if (o_res.on_edge) n_edge++;
            if (pending_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result %b", o_res);
            end else begin
                pist_pkg::t_res e;
                e = pending_res.pop_front();
                if (e !== o_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result exp inside=%b edge=%b few=%b got %b%b%b",
                                 e.inside_res, e.on_edge, e.too_few_vertices,
                                 o_res.inside_res, o_res.on_edge, o_res.too_few_vertices);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one write, then a quiet wait so the enable drops before the next write
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            pist_pkg::REG_SHAPE_KIND:   kind_q  = val[1:0];
            pist_pkg::REG_TRANSFORM:    xform_q = val;
            pist_pkg::REG_UPPER_BOUND:  upper_q = val;
            pist_pkg::REG_LOWER_BOUND:  lower_q = val;
            pist_pkg::REG_VERTEX_COUNT: nvert_q = val[6:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // drain outstanding results, then let the back end settle
    task automatic settle();
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // drop start after every transfer; busy rises after it anyway while the front maps the command
    task automatic send_cmd(pist_pkg::t_cmd c);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end else begin
            @(posedge i_clk);
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // accepted at this edge
        if (c.func == pist_pkg::FUNC_LOAD) begin
            vx[c.vertex_slot] = c.coord_a;
            vy[c.vertex_slot] = c.coord_b;
        end else begin
            pending_res = {pending_res, shape_result(c)};
        end
        start <= 1'b0;
    endtask

    task automatic load_vertex(int slot, int xa, int yb);
        pist_pkg::t_cmd c;
        c.func = pist_pkg::FUNC_LOAD; c.vertex_slot = 6'(slot);
        c.coord_a = xa; c.coord_b = yb;
        send_cmd(c);
    endtask

    task automatic test_point(logic [31:0] a, logic [31:0] b);
        pist_pkg::t_cmd c;
        c.func = pist_pkg::FUNC_TEST; c.vertex_slot = 6'($urandom);
        c.coord_a = a; c.coord_b = b;
        send_cmd(c);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        endcase
    endfunction

    task automatic fill_table();
        for (int i = 0; i < NVERT; i++)
            load_vertex(i, 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16)),
                        32'($signed($urandom_range(0, 16 << 16)) - (8 << 16)));
    endtask

    // side-8 square at origin, corners and edges; then vertex counts, circle, rect, unused kind
    task automatic test_directed();
        load_vertex(0, -4 << 16, -4 << 16);
        load_vertex(1,  4 << 16, -4 << 16);
        load_vertex(2,  4 << 16,  4 << 16);
        load_vertex(3, -4 << 16,  4 << 16);
        settle();
        write_reg(pist_pkg::REG_SHAPE_KIND, 64'(pist_pkg::SHAPE_POLY));
        write_reg(pist_pkg::REG_UPPER_BOUND, {32'sd5 << 16, 32'sd5 << 16});
        write_reg(pist_pkg::REG_LOWER_BOUND, {-(32'sd5 << 16), -(32'sd5 << 16)});
        write_reg(pist_pkg::REG_VERTEX_COUNT, 64'd4);
        test_point(0, 0);
        test_point(4 << 16, 0);              // on an edge
        test_point(-4 << 16, -4 << 16);      // on a corner
        test_point((4 << 16) + 40, 1 << 16); // near the edge
        test_point(6 << 16, 0);              // outside the box
        test_point(32'h7fffffff, 32'h80000000);
        settle();
        write_reg(pist_pkg::REG_VERTEX_COUNT, 64'd2);
        test_point(0, 0);
        settle();
        write_reg(pist_pkg::REG_VERTEX_COUNT, 64'd127);
        fill_table();
        test_point(0, 0);
        settle();
        write_reg(pist_pkg::REG_SHAPE_KIND, 64'(pist_pkg::SHAPE_CIRCLE));
        write_reg(pist_pkg::REG_UPPER_BOUND, {32'sd3 << 16, 32'h0});
        test_point(3 << 16, 0);
        test_point(32'h80000000, 32'h80000000);
        settle();
        write_reg(pist_pkg::REG_SHAPE_KIND, 64'(pist_pkg::SHAPE_RECT));
        write_reg(pist_pkg::REG_UPPER_BOUND, {32'sd2 << 16, 32'sd1 << 16});
        test_point(2 << 16, -(1 << 16));
        test_point(2 << 16, 32'hfffe_ffff);
        settle();
        // unused shape kind
        write_reg(pist_pkg::REG_SHAPE_KIND, 64'd3);
        test_point(0, 0);
        settle();
    endtask

    task automatic test_random_shapes();
        int seg;
        logic [63:0] m;
        for (int s = 0; s < 24; s++) begin
            seg = s % 3;
            case ($urandom_range(0, 3))
                0: m = pist_pkg::TRANSFORM_RESET;
                1: m = {$urandom, $urandom};
                2: m = 64'h7fff_8000_8000_7fff;
                default: m = {16'h4000 + 16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)),
                              16'($urandom_range(0, 2047)), 16'h3c00};
            endcase
            write_reg(pist_pkg::REG_TRANSFORM, m);
            write_reg(pist_pkg::REG_SHAPE_KIND, 64'(seg));
            if (seg == 2) begin
                write_reg(pist_pkg::REG_UPPER_BOUND,
                          ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} :
                          {32'sd9 << 16, 32'sd9 << 16});
                write_reg(pist_pkg::REG_LOWER_BOUND,
                          ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} :
                          {-(32'sd9 << 16), -(32'sd9 << 16)});
                write_reg(pist_pkg::REG_VERTEX_COUNT, ($urandom_range(0, 5) == 0) ?
                          64'($urandom_range(0, 127)) : 64'($urandom_range(3, 12)));
                fill_table();
            end else begin
                write_reg(pist_pkg::REG_UPPER_BOUND,
                          ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
                          {32'($urandom_range(0, 10 << 16)), 32'($urandom_range(0, 10 << 16))});
            end
            repeat (45) begin
                if (seg == 2 && $urandom_range(0, 9) == 0)
                    load_vertex($urandom_range(0, NVERT - 1), rand_coord(), rand_coord());
                else
                    test_point(rand_coord(), rand_coord());
            end
            settle();
        end
        write_reg(pist_pkg::REG_LOWER_BOUND, 64'hffff_ffff_ffff_ffff);
        write_reg(pist_pkg::REG_VERTEX_COUNT, 64'd0);
        write_reg(pist_pkg::REG_VERTEX_COUNT, 64'd64);
        write_reg(pist_pkg::REG_TRANSFORM, pist_pkg::TRANSFORM_RESET);
        test_point(rand_coord(), rand_coord());
        settle();
    endtask

    initial begin
        kind_q = pist_pkg::SHAPE_CIRCLE; xform_q = pist_pkg::TRANSFORM_RESET;
        upper_q = '0; lower_q = '0; nvert_q = '0;
        foreach (vx[i]) begin vx[i] = 0; vy[i] = 0; end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_directed();
        test_random_shapes();
        $display("Covered %0d results (%0d inside, %0d on an edge) across circle,", n_results,
                 n_inside, n_edge);
        $display("rectangle, polygon and unused shape kinds with random transforms.");
        if (mismatches == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
